@@ hw/rtl/arfs_pkg.sv @@
package arfs_pkg;

	// Largest window side accepted, by default.
	localparam int unsigned MAX_KERNEL_DEF = 255;

	localparam int unsigned SIDE_W  = 8;
	localparam int unsigned AREA_W  = 2 * SIDE_W;
	localparam int unsigned MULT_W  = 8;
	localparam int unsigned SHIFT_W = 5;
	localparam int unsigned NUMER_W = 23;

	// Extra scale applied to the area when bounding the shift search.
	localparam int unsigned SEARCH_SCALE_LOG2 = 7;

	// Fixed pairs for the common square windows.
	localparam logic [SIDE_W-1:0]  K3_SIDE   = 8'd3;
	localparam logic [MULT_W-1:0]  K3_MULT   = 8'd7;
	localparam logic [SHIFT_W-1:0] K3_SHIFT  = 5'd6;
	localparam logic [SIDE_W-1:0]  K5_SIDE   = 8'd5;
	localparam logic [MULT_W-1:0]  K5_MULT   = 8'd10;
	localparam logic [SHIFT_W-1:0] K5_SHIFT  = 5'd8;
	localparam logic [SIDE_W-1:0]  K6_SIDE   = 8'd6;
	localparam logic [MULT_W-1:0]  K6_MULT   = 8'd7;
	localparam logic [SHIFT_W-1:0] K6_SHIFT  = 5'd8;
	localparam logic [SIDE_W-1:0]  K7_SIDE   = 8'd7;
	localparam logic [MULT_W-1:0]  K7_MULT   = 8'd21;
	localparam logic [SHIFT_W-1:0] K7_SHIFT  = 5'd10;
	localparam logic [SIDE_W-1:0]  K14_SIDE  = 8'd14;
	localparam logic [MULT_W-1:0]  K14_MULT  = 8'd21;
	localparam logic [SHIFT_W-1:0] K14_SHIFT = 5'd12;

	// Largest shift the search can produce.
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd22;
	// Largest multiplier the search can produce.
	localparam logic [MULT_W-1:0]  MULT_MAX  = 8'd128;

	typedef struct packed {
		logic [SIDE_W-1:0] kernel_height;
		logic [SIDE_W-1:0] kernel_width;
	} kernel_t;

	typedef struct packed {
		logic [MULT_W-1:0]  multiplier;
		logic [SHIFT_W-1:0] shift_amount;
		logic [NUMER_W-1:0] coefficient_numerator;
	} factor_t;

endpackage

@@ hw/rtl/avgpool_reciprocal_factor_search.sv @@
// Channel   | Ports              | Handshake
// ----------+--------------------+-------------------------------------------
// window in | start, kernel      | taken at a clock edge with start & !busy
// factor out| done, result       | one-cycle strobe, no back-pressure
//
// Sequence: a transaction sets up the area, then runs the shift search unless
// the window is tabled (3x3, 5x5, 6x6, 7x7, 14x14), and ends with the final
// area * multiplier product. The search takes one restoring-division step of
// the shared compare/subtract unit per candidate shift, plus a loop exit.
// Reset: arst_n clears the sequencer and the done strobe; result holds junk
// until the first transaction completes.
// Stalls: busy stays high from acceptance until done is raised; done is
// high for exactly one cycle and the receiver cannot stall it.
module avgpool_reciprocal_factor_search #(
	parameter int unsigned MAX_KERNEL = arfs_pkg::MAX_KERNEL_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  arfs_pkg::kernel_t kernel,
	output logic              done,
	output arfs_pkg::factor_t result
);
	import arfs_pkg::*;

	// Saturation value for a side; the input port cannot exceed 8 bits.
	localparam int unsigned SIDE_CAP = (MAX_KERNEL < 255) ? MAX_KERNEL : 255;
	localparam logic [SIDE_W-1:0] SIDE_CAP_C = SIDE_CAP[SIDE_W-1:0];

	localparam int unsigned LIMIT_W = AREA_W + SEARCH_SCALE_LOG2;
	localparam int unsigned PW_W    = LIMIT_W + 1;
	localparam int unsigned SCL_W   = AREA_W + 1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_AREA   = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_NUMER  = 2'd3;

	logic [1:0]         state_q;
	logic [SIDE_W-1:0]  kh_q, kw_q;
	logic [AREA_W-1:0]  area_q;
	// Running quotient and remainder of 2^s / area.
	logic [MULT_W-1:0]  quot_q;
	logic [AREA_W-1:0]  rem_q;
	logic [SHIFT_W-1:0] shift_q;
	// One-hot 2^s, used to end the search.
	logic [PW_W-1:0]    pow_q;
	// Best error scaled to the current shift; stops doubling once it reaches 2^AREA_W.
	logic [SCL_W-1:0]   best_scl_q;
	logic [MULT_W-1:0]  best_mult_q;
	logic [SHIFT_W-1:0] best_shift_q;
	logic               done_q;
	factor_t            result_q;

	logic [SIDE_W-1:0]  kh_clamp, kw_clamp;
	logic [AREA_W-1:0]  area_prod;
	logic               tabled;
	logic [MULT_W-1:0]  tab_mult;
	logic [SHIFT_W-1:0] tab_shift;
	logic [SCL_W-1:0]   rem_dbl;
	logic               round_up;
	logic [SCL_W-1:0]   rem_sub;
	logic [MULT_W-1:0]  cand_mult;
	logic [AREA_W-1:0]  cand_err;
	logic               cand_wins;
	logic [LIMIT_W-1:0] limit;
	logic               search_on;
	logic [AREA_W+MULT_W-1:0] numer_prod;

	// Zero sides count as one; oversized sides saturate.
	always_comb begin
		kh_clamp = kernel.kernel_height;
		kw_clamp = kernel.kernel_width;
		if (kh_clamp == '0) begin
			kh_clamp = {{(SIDE_W-1){1'b0}}, 1'b1};
		end
		if (kw_clamp == '0) begin
			kw_clamp = {{(SIDE_W-1){1'b0}}, 1'b1};
		end
		if (kh_clamp > SIDE_CAP_C) begin
			kh_clamp = SIDE_CAP_C;
		end
		if (kw_clamp > SIDE_CAP_C) begin
			kw_clamp = SIDE_CAP_C;
		end
	end

	assign area_prod = kh_q * kw_q;

	// Fixed pairs for the common square windows.
	always_comb begin
		tabled    = 1'b1;
		tab_mult  = '0;
		tab_shift = '0;
		if (kh_q == K3_SIDE && kw_q == K3_SIDE) begin
			tab_mult  = K3_MULT;
			tab_shift = K3_SHIFT;
		end else if (kh_q == K5_SIDE && kw_q == K5_SIDE) begin
			tab_mult  = K5_MULT;
			tab_shift = K5_SHIFT;
		end else if (kh_q == K6_SIDE && kw_q == K6_SIDE) begin
			tab_mult  = K6_MULT;
			tab_shift = K6_SHIFT;
		end else if (kh_q == K7_SIDE && kw_q == K7_SIDE) begin
			tab_mult  = K7_MULT;
			tab_shift = K7_SHIFT;
		end else if (kh_q == K14_SIDE && kw_q == K14_SIDE) begin
			tab_mult  = K14_MULT;
			tab_shift = K14_SHIFT;
		end else begin
			tabled = 1'b0;
		end
	end

	// Shared compare/subtract unit: one restoring-division step. The same
	// compare decides round-half-up for the candidate at this shift.
	assign rem_dbl   = {rem_q, 1'b0};
	assign round_up  = rem_dbl >= {1'b0, area_q};
	assign rem_sub   = rem_dbl - {1'b0, area_q};
	assign cand_mult = quot_q + {{(MULT_W-1){1'b0}}, round_up};
	assign cand_err  = round_up ? (area_q - rem_q) : rem_q;
	// Strictly smaller wins, so the first of equal errors is kept.
	assign cand_wins = {1'b0, cand_err} < best_scl_q;

	// Search shifts while 2^s < area * 128.
	assign limit     = {area_q, {SEARCH_SCALE_LOG2{1'b0}}};
	assign search_on = pow_q < {1'b0, limit};

	assign numer_prod = area_q * best_mult_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_AREA;
					end
				end
				ST_AREA: begin
					state_q <= tabled ? ST_NUMER : ST_SEARCH;
				end
				ST_SEARCH: begin
					if (!search_on) begin
						state_q <= ST_NUMER;
					end
				end
				ST_NUMER: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					kh_q <= kh_clamp;
					kw_q <= kw_clamp;
				end
			end
			ST_AREA: begin
				area_q       <= area_prod;
				shift_q      <= '0;
				pow_q        <= {{(PW_W-1){1'b0}}, 1'b1};
				// Starting error of one, scaled by area at shift zero.
				best_scl_q   <= {1'b0, area_prod};
				best_mult_q  <= tab_mult;
				best_shift_q <= tab_shift;
				// 2^0 / area: quotient one only for a unit window.
				if (area_prod == {{(AREA_W-1){1'b0}}, 1'b1}) begin
					quot_q <= {{(MULT_W-1){1'b0}}, 1'b1};
					rem_q  <= '0;
				end else begin
					quot_q <= '0;
					rem_q  <= {{(AREA_W-1){1'b0}}, 1'b1};
				end
			end
			ST_SEARCH: begin
				if (search_on) begin
					if (cand_wins) begin
						best_mult_q  <= cand_mult;
						best_shift_q <= shift_q;
						best_scl_q   <= {cand_err, 1'b0};
					end else if (!best_scl_q[SCL_W-1]) begin
						best_scl_q <= {best_scl_q[SCL_W-2:0], 1'b0};
					end
					// Advance the division by one bit.
					if (round_up) begin
						rem_q  <= rem_sub[AREA_W-1:0];
						quot_q <= {quot_q[MULT_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_dbl[AREA_W-1:0];
						quot_q <= {quot_q[MULT_W-2:0], 1'b0};
					end
					shift_q <= shift_q + 5'd1;
					pow_q   <= {pow_q[PW_W-2:0], 1'b0};
				end
			end
			ST_NUMER: begin
				result_q.multiplier            <= best_mult_q;
				result_q.shift_amount          <= best_shift_q;
				result_q.coefficient_numerator <= numer_prod[NUMER_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// The strobe only fires once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// Each transaction passes through the idle, area and numerator states in turn, so done never repeats.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.shift_amount <= SHIFT_MAX)
		else $error("shift out of range");

	a_mult_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.multiplier <= MULT_MAX)
		else $error("multiplier out of range");

	// The search must stop before the shift counter passes its bound.
	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> shift_q <= SHIFT_MAX + 5'd1)
		else $error("search ran past the last shift");

endmodule
